>>> hw/rtl/iss_pkg.sv
`timescale 1ns / 1ps

package iss_pkg;

  localparam int STEP_W  = 3;
  localparam int DWELL_W = 16;
  localparam int REQ_W   = 2;
  localparam int ADDR_W  = 3;

  // request codes
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;

  // register indexes
  localparam logic [ADDR_W-1:0] CFG_STEP_COUNT = 3'd0;
  localparam logic [ADDR_W-1:0] CFG_DWELL_BASE = 3'd1;

  typedef struct packed {
    logic [STEP_W-1:0]  step_idx;
    logic [DWELL_W-1:0] tick_cnt;
    logic               running;
    logic               done_res;
    logic               advanced;
  } iss_res_t;

endpackage

>>> hw/rtl/interlocked_step_sequencer_top.sv
`timescale 1ns / 1ps

// interlocked step sequencer: each transfer on the in_ channel is a tick, a
// start, a stop or an unused code, and gives exactly one result transfer on the out_ channel
// with the step, elapsed ticks, running, done and advanced flags after it.
// one item per clock is sustained while out_ready is high; the input transfer
// loads the input register, and a later edge does the state update and loads
// the result register, which raises out_valid; the result transfer follows
// once out_ready is high.
// the state update is a single compare/increment pass, so a new item follows
// every cycle while out_ready is high. configuration (cfg_we/cfg_addr/
// cfg_wdata) is index 0 step count, 1..6 the dwell of step 0..5 in ticks;
// write it only while no transfer is in flight. MAX_STEPS sets how many dwell
// registers exist, TIME_BITS the width of the saturating elapsed counter
// (out_elapsed_ticks carries its low 16 bits).
module interlocked_step_sequencer_top import iss_pkg::*; #(
  parameter int MAX_STEPS = 6,
  parameter int TIME_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic [ADDR_W-1:0]  cfg_addr,
  input  logic [DWELL_W-1:0] cfg_wdata,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic               in_interlock_ok,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STEP_W-1:0]  out_current_step,
  output logic [DWELL_W-1:0] out_elapsed_ticks,
  output logic               out_running,
  output logic               out_done_res,
  output logic               out_advanced
);

  logic [STEP_W-1:0]                 n_steps;
  logic [MAX_STEPS-1:0][DWELL_W-1:0] dwell;

  // input register
  logic             stg_v_r;
  logic [REQ_W-1:0] stg_req_r;
  logic             stg_ilk_r;

  // result register
  logic     out_v_r;
  iss_res_t out_res_r;
  iss_res_t res;

  logic fire;

  // staged item moves on when the result register is empty or draining
  assign fire     = stg_v_r && (!out_v_r || out_ready);
  assign in_ready = !stg_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_ready) begin
      stg_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_req_r <= in_req_type;
      stg_ilk_r <= in_interlock_ok;
    end
  end

  iss_cfg_regs #(
    .MAX_STEPS (MAX_STEPS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .n_steps   (n_steps),
    .dwell     (dwell)
  );

  // state registers update only when the item is committed to the result
  iss_step_core #(
    .MAX_STEPS (MAX_STEPS),
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (fire),
    .req_type (stg_req_r),
    .ilk_ok   (stg_ilk_r),
    .n_steps  (n_steps),
    .dwell    (dwell),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_v_r;
  assign out_current_step  = out_res_r.step_idx;
  assign out_elapsed_ticks = out_res_r.tick_cnt;
  assign out_running       = out_res_r.running;
  assign out_done_res      = out_res_r.done_res;
  assign out_advanced      = out_res_r.advanced;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ready) |-> !fire)
    else $error("result overwritten before transfer");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ready) |=> (out_v_r && $stable(out_res_r)))
    else $error("stalled result changed");

  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_v_r && !fire) |=> (stg_v_r && $stable(stg_req_r) && $stable(stg_ilk_r)))
    else $error("staged item lost while stalled");

endmodule

>>> hw/rtl/iss_cfg_regs.sv
`timescale 1ns / 1ps

module iss_cfg_regs import iss_pkg::*; #(
  parameter int MAX_STEPS = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ADDR_W-1:0]               cfg_addr,
  input  logic [DWELL_W-1:0]              cfg_wdata,
  output logic [STEP_W-1:0]               n_steps,
  output logic [MAX_STEPS-1:0][DWELL_W-1:0] dwell
);

  logic [STEP_W-1:0]                n_steps_r;
  logic [MAX_STEPS-1:0][DWELL_W-1:0] dwell_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_steps_r <= STEP_W'(1);
      dwell_r   <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_STEP_COUNT) begin
        n_steps_r <= cfg_wdata[STEP_W-1:0];
      end
      for (int i = 0; i < MAX_STEPS; i++) begin
        if (cfg_addr == ADDR_W'(int'(CFG_DWELL_BASE) + i)) begin
          dwell_r[i] <= cfg_wdata;
        end
      end
    end
  end

  assign n_steps = n_steps_r;
  assign dwell   = dwell_r;

endmodule

>>> hw/rtl/iss_step_core.sv
`timescale 1ns / 1ps

module iss_step_core import iss_pkg::*; #(
  parameter int MAX_STEPS = 6,
  parameter int TIME_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic [REQ_W-1:0]                  req_type,
  input  logic                              ilk_ok,
  input  logic [STEP_W-1:0]                 n_steps,
  input  logic [MAX_STEPS-1:0][DWELL_W-1:0] dwell,
  output iss_res_t                          res
);

  localparam int CMP_W = (TIME_BITS > DWELL_W) ? TIME_BITS : DWELL_W;

  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic                 adv;

  logic [STEP_W-1:0]    n_active;
  logic [DWELL_W-1:0]   cur_dwell;
  logic [TIME_BITS-1:0] time_inc;
  logic [STEP_W-1:0]    step_inc;

  // step count clamped to the steps that exist
  assign n_active = (n_steps > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : n_steps;

  always_comb begin
    cur_dwell = '0;
    for (int i = 0; i < MAX_STEPS; i++) begin
      if (step_r == STEP_W'(i)) begin
        cur_dwell = dwell[i];
      end
    end
  end

  // saturating elapsed count
  assign time_inc = (time_r == '1) ? time_r : time_r + TIME_BITS'(1);
  assign step_inc = step_r + STEP_W'(1);

  always_comb begin
    step_nxt = step_r;
    time_nxt = time_r;
    run_nxt  = run_r;
    done_nxt = done_r;
    adv      = 1'b0;
    priority if (req_type == REQ_START) begin
      step_nxt = '0;
      time_nxt = '0;
      run_nxt  = 1'b1;
      done_nxt = 1'b0;
    end else if (req_type == REQ_STOP) begin
      step_nxt = '0;
      time_nxt = '0;
      run_nxt  = 1'b0;
      done_nxt = 1'b0;
    end else if (req_type == REQ_TICK && run_r && !done_r) begin
      if (step_r >= n_active) begin
        // count zero or lowered below the current step
        done_nxt = 1'b1;
        run_nxt  = 1'b0;
      end else begin
        time_nxt = time_inc;
        if (ilk_ok &&
            (cur_dwell == '0 || CMP_W'(time_inc) >= CMP_W'(cur_dwell))) begin
          step_nxt = step_inc;
          time_nxt = '0;
          adv      = 1'b1;
          if (step_inc >= n_active) begin
            done_nxt = 1'b1;
            run_nxt  = 1'b0;
          end
        end
      end
    end else begin
      // idle tick or unused code: state unchanged
      adv = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      time_r <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else if (en) begin
      step_r <= step_nxt;
      time_r <= time_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign res.step_idx = step_nxt;
  assign res.tick_cnt = DWELL_W'(time_nxt);
  assign res.running  = run_nxt;
  assign res.done_res = done_nxt;
  assign res.advanced = adv;

  a_run_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(run_r && done_r))
    else $error("running and done both set");

  a_run_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (step_r < STEP_W'(MAX_STEPS)))
    else $error("running with step beyond last");

  a_adv_clears_time: assert property (@(posedge clk) disable iff (!rst_n)
    (en && adv) |=> (time_r == '0 && step_r == $past(step_inc)))
    else $error("advance did not move step and clear time");

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (en && req_type == REQ_STOP) |=>
      (step_r == '0 && time_r == '0 && !run_r && !done_r))
    else $error("stop left state behind");

endmodule

>>> test/interlocked_step_sequencer_top_tb.sv
`timescale 1ns / 1ps

module interlocked_step_sequencer_top_tb;
  import iss_pkg::*;

  // block configuration as instantiated (defaults)
  localparam int MAX_STEPS = 6;

  // request code the block must ignore
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  // register index with no register behind it
  localparam logic [ADDR_W-1:0] CFG_SPARE = 3'd7;

  localparam int DRAIN_CYCLES   = 6;     // input and result registers to pass, leave some margin
  localparam int HOLD_LEN       = 200;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer and no register write
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_ITEMS    = 100;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             ilk;
  } seq_cmd_t;

  // dut ports
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [ADDR_W-1:0]  cfg_addr = '0;
  logic [DWELL_W-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [REQ_W-1:0]   in_req_type = REQ_TICK;
  logic               in_interlock_ok = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [STEP_W-1:0]  out_current_step;
  logic [DWELL_W-1:0] out_elapsed_ticks;
  logic               out_running;
  logic               out_done_res;
  logic               out_advanced;

  // shadow sequencer: configuration and state
  logic [STEP_W-1:0]  step_total;
  logic [DWELL_W-1:0] dwell_tab [MAX_STEPS];
  logic [STEP_W-1:0]  seq_step;
  logic [DWELL_W-1:0] seq_time;
  logic               seq_run;
  logic               seq_done;

  // commands waiting to be driven, results waiting to be seen
  seq_cmd_t cmd_q [$];
  iss_res_t expected_q [$];
  seq_cmd_t next_cmd;
  iss_res_t want;

  // handshake bookkeeping
  bit in_fire;
  bit out_fire;
  int in_gap;
  int out_wait;
  int in_gap_max = 0;
  int out_gap_max = 0;
  int hold_order = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  // run statistics
  int items_queued = 0;
  int items_sent = 0;
  int results_seen = 0;
  int adv_count = 0;
  int done_count = 0;
  int fail_count = 0;

  interlocked_step_sequencer_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_interlock_ok   (in_interlock_ok),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_current_step  (out_current_step),
    .out_elapsed_ticks (out_elapsed_ticks),
    .out_running       (out_running),
    .out_done_res      (out_done_res),
    .out_advanced      (out_advanced)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // state after reset: one step, all dwells zero, idle
  function automatic void reset_shadow();
    step_total = 3'd1;
    for (int i = 0; i < MAX_STEPS; i++) dwell_tab[i] = '0;
    seq_step = '0;
    seq_time = '0;
    seq_run  = 1'b0;
    seq_done = 1'b0;
  endfunction

  // apply one command to the shadow sequencer and return the result it gives
  function automatic iss_res_t next_seq_result(input logic [REQ_W-1:0] req,
                                               input logic ilk);
    iss_res_t           res;
    logic [STEP_W-1:0]  n;
    logic [DWELL_W-1:0] d;
    logic               moved;
    moved = 1'b0;
    case (req)
      REQ_START: begin
        seq_step = '0;
        seq_time = '0;
        seq_run  = 1'b1;
        seq_done = 1'b0;
      end
      REQ_STOP: begin
        seq_step = '0;
        seq_time = '0;
        seq_run  = 1'b0;
        seq_done = 1'b0;
      end
      REQ_TICK: begin
        // ticks only count while running and not yet done
        if (seq_run && !seq_done) begin
          // step count above the number of dwell registers is clamped
          if (step_total > 3'(MAX_STEPS)) n = 3'(MAX_STEPS);
          else n = step_total;
          if (seq_step >= n) begin
            // count was zero or lowered under the current step
            seq_done = 1'b1;
            seq_run  = 1'b0;
          end else begin
            d = dwell_tab[seq_step];
            if (seq_time != '1) seq_time = seq_time + DWELL_W'(1);
            if (ilk && (d == '0 || seq_time >= d)) begin
              seq_step = seq_step + STEP_W'(1);
              seq_time = '0;
              moved    = 1'b1;
              if (seq_step >= n) begin
                seq_done = 1'b1;
                seq_run  = 1'b0;
              end
            end
          end
        end
      end
      default: begin
        // unused code: state unchanged
      end
    endcase
    res.step_idx = seq_step;
    res.tick_cnt = seq_time;
    res.running  = seq_run;
    res.done_res = seq_done;
    res.advanced = moved;
    return res;
  endfunction

  // monitor: sample both channels at the rising edge, predict on input
  // transfers, check on result transfers
  always @(posedge clk) begin
    in_fire  = rst_n && in_valid && in_ready;
    out_fire = rst_n && out_valid && out_ready;
    if (in_fire) begin
      expected_q.push_back(next_seq_result(in_req_type, in_interlock_ok));
      items_sent++;
    end
    if (out_fire) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected: step %0d elapsed %0d",
               out_current_step, out_elapsed_ticks);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        results_seen++;
        if (out_current_step !== want.step_idx) begin
          $error("out_current_step mismatch: expected %0d, actual %0d",
                 want.step_idx, out_current_step);
          fail_count++;
        end
        if (out_elapsed_ticks !== want.tick_cnt) begin
          $error("out_elapsed_ticks mismatch: expected %0d, actual %0d",
                 want.tick_cnt, out_elapsed_ticks);
          fail_count++;
        end
        if (out_running !== want.running) begin
          $error("running mismatch: expected %0d, actual %0d",
                 want.running, out_running);
          fail_count++;
        end
        if (out_done_res !== want.done_res) begin
          $error("done_res mismatch: expected %0d, actual %0d",
                 want.done_res, out_done_res);
          fail_count++;
        end
        if (out_advanced !== want.advanced) begin
          $error("advanced mismatch: expected %0d, actual %0d",
                 want.advanced, out_advanced);
          fail_count++;
        end
        if (want.advanced) adv_count++;
        if (want.advanced && want.done_res) done_count++;
      end
    end
  end

  // driver: offer the next command at the falling edge, hold it until the
  // transfer, then sit out a random gap
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // still waiting for in_ready, payload held
    end else if (in_gap > 0) begin
      in_gap--;
      in_valid <= 1'b0;
    end else if (cmd_q.size() > 0) begin
      next_cmd = cmd_q.pop_front();
      in_valid        <= 1'b1;
      in_req_type     <= next_cmd.req;
      in_interlock_ok <= next_cmd.ilk;
      in_gap = $urandom_range(0, in_gap_max);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: random stall after each result transfer, plus a long hold-off
  // on request, counted here
  always @(negedge clk) begin
    if (hold_order != hold_served) begin
      hold_served = hold_order;
      hold_left   = HOLD_LEN;
    end
    if (out_fire) out_wait = $urandom_range(0, out_gap_max);
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               stall_cycles, expected_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send(input logic [REQ_W-1:0] req, input logic ilk);
    seq_cmd_t c;
    c.req = req;
    c.ilk = ilk;
    cmd_q.push_back(c);
    items_queued++;
  endtask

  // wait until every command went through and every result came back
  task automatic settle();
    while (items_sent != items_queued || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write, only called while nothing is in flight
  task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [DWELL_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    if (idx == CFG_STEP_COUNT) step_total = val[STEP_W-1:0];
    else if (idx >= CFG_DWELL_BASE && idx < CFG_DWELL_BASE + MAX_STEPS)
      dwell_tab[idx - CFG_DWELL_BASE] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_dwells(input int hi);
    for (int i = 0; i < MAX_STEPS; i++)
      write_reg(CFG_DWELL_BASE + 3'(i), 16'($urandom_range(0, hi)));
  endtask

  // mostly start-then-ticks sequences with random interlock, some noise
  task automatic random_phase(input int n_items);
    int sent;
    int run_len;
    int r;
    sent = 0;
    while (sent < n_items) begin
      send(REQ_START, 1'($urandom_range(0, 1)));
      run_len = $urandom_range(3, 28);
      sent += run_len + 1;
      repeat (run_len) begin
        r = $urandom_range(0, 99);
        if (r < 88) send(REQ_TICK, ($urandom_range(0, 3) != 0));
        else if (r < 93) send(REQ_START, 1'($urandom_range(0, 1)));
        else if (r < 97) send(REQ_STOP, 1'($urandom_range(0, 1)));
        else send(REQ_UNUSED, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    reset_shadow();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed: three steps, dwell zero / two / one
    in_gap_max  = 14;
    out_gap_max = 14;
    write_reg(CFG_STEP_COUNT, 16'd3);
    write_reg(CFG_DWELL_BASE + 3'd0, 16'd0);
    write_reg(CFG_DWELL_BASE + 3'd1, 16'd2);
    write_reg(CFG_DWELL_BASE + 3'd2, 16'd1);
    write_reg(CFG_DWELL_BASE + 3'd3, 16'd0);
    write_reg(CFG_DWELL_BASE + 3'd4, 16'd0);
    write_reg(CFG_DWELL_BASE + 3'd5, 16'd0);
    send(REQ_TICK, 1'b1);    // tick while idle
    send(REQ_UNUSED, 1'b0);  // unused code while idle
    send(REQ_START, 1'b0);
    send(REQ_TICK, 1'b0);    // dwell zero but interlock not ok, no advance
    send(REQ_TICK, 1'b1);    // dwell zero, advance
    send(REQ_TICK, 1'b1);    // under dwell
    send(REQ_UNUSED, 1'b1);  // unused code while running
    send(REQ_TICK, 1'b0);
    send(REQ_TICK, 1'b1);    // dwell met, advance
    send(REQ_TICK, 1'b1);    // last step, done
    send(REQ_TICK, 1'b1);    // tick after done
    send(REQ_START, 1'b1);   // restart from done
    send(REQ_TICK, 1'b1);
    send(REQ_START, 1'b0);   // restart while running
    send(REQ_STOP, 1'b1);
    send(REQ_TICK, 1'b1);
    send(REQ_START, 1'b1);
    send(REQ_TICK, 1'b1);
    send(REQ_TICK, 1'b1);
    send(REQ_TICK, 1'b1);    // now in step two
    settle();
    // count lowered under the current step while running
    write_reg(CFG_STEP_COUNT, 16'd1);
    send(REQ_TICK, 1'b1);
    send(REQ_STOP, 1'b0);
    settle();
    // step count zero, upper data bits set and ignored
    write_reg(CFG_STEP_COUNT, 16'hFFF8);
    send(REQ_START, 1'b1);
    send(REQ_TICK, 1'b1);
    settle();
    // count above the register file, all dwells zero, write to spare index
    write_reg(CFG_STEP_COUNT, 16'd7);
    load_dwells(0);
    write_reg(CFG_SPARE, 16'hFFFF);
    send(REQ_START, 1'b0);
    repeat (7) send(REQ_TICK, 1'b1);
    settle();

    // random phases with varied settings and idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          write_reg(CFG_STEP_COUNT, 16'd6);
          load_dwells(3);
          in_gap_max  = 14;
          out_gap_max = 14;
        end
        1: begin
          write_reg(CFG_STEP_COUNT, 16'd7);
          load_dwells(2);
          in_gap_max  = 0;
          out_gap_max = 14;
        end
        2: begin
          write_reg(CFG_STEP_COUNT, 16'($urandom_range(1, 6)));
          load_dwells(4);
          in_gap_max  = 14;
          out_gap_max = 0;
        end
        3: begin
          // second step can never be left on time within the phase
          write_reg(CFG_STEP_COUNT, 16'd2);
          load_dwells(0);
          write_reg(CFG_DWELL_BASE + 3'd1, 16'hFFFF);
          in_gap_max  = 0;
          out_gap_max = 0;
        end
        default: begin
          write_reg(CFG_STEP_COUNT, 16'($urandom_range(0, 7)));
          load_dwells(5);
          in_gap_max  = $urandom_range(0, 14);
          out_gap_max = $urandom_range(0, 14);
        end
      endcase
      random_phase(PHASE_ITEMS);
      // back-pressure: receiver stops while the sender keeps offering
      if (p == 1) hold_order++;
      settle();
    end

    $display("%0d commands sent, %0d results checked (directed, %0d random phases)",
             items_sent, results_seen, RANDOM_PHASES);
    $display("%0d step advances, %0d sequences finished", adv_count, done_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
